/* sv/three_band_stereo_level_meter_core_macros.svh */
// assertion macros for the three-band stereo level meter
// used by the port checker; no other dependencies
`ifndef THREE_BAND_STEREO_LEVEL_METER_CORE_MACROS_SVH
`define THREE_BAND_STEREO_LEVEL_METER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TBSLM_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tbslm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TBSLM_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tbslm assertion failed");

`endif

/* sv/tbslm_pkg.sv */
// shared types and constants for the three-band stereo level meter
// no dependencies
`timescale 1ns / 1ps

package tbslm_pkg;

    localparam int SMP_W     = 16;
    localparam int SUM_W     = 23;
    localparam int MAG_W     = 16;
    localparam int PEAK_W    = 16;
    localparam int LVL_W     = 4;
    localparam int NCH       = 2;
    localparam int NBANDS    = 6;
    localparam int BAND_W    = 3;
    localparam int DIVD_W    = SUM_W;
    localparam int DIVS_W    = 16;
    localparam int DIV_CNT_W = 5;

    localparam int SLOW_SH   = 4;
    localparam int FAST_SH   = 2;
    localparam int DECAY_SH  = 5;

    localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
    localparam logic [PEAK_W-1:0] PEAK_FLOOR = PEAK_W'(64);
    localparam logic [LVL_W-1:0]  LVL_MAX    = LVL_W'(15);
    localparam logic [LVL_W-1:0]  LVL_CLIMB  = LVL_W'(3);
    localparam logic [BAND_W-1:0] LAST_BAND  = BAND_W'(NBANDS - 1);

    typedef logic signed [SMP_W-1:0] sample_t;
    typedef logic [LVL_W-1:0]        level_t;
    typedef logic [SUM_W-1:0]        sum_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_FILT,
        ST_ACC,
        ST_E_START,
        ST_E_WAIT,
        ST_PEAK,
        ST_T_START,
        ST_T_WAIT,
        ST_LEVEL
    } tbslm_state_t;

    // per-frame datapath controls from the sequencer
    typedef struct packed {
        logic seed;
        logic filt;
        logic acc;
        logic ch;
    } frame_ctrl_t;

endpackage

/* sv/tbslm_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on tbslm_pkg
`timescale 1ns / 1ps

module tbslm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tbslm_pkg::DIVD_W-1:0]   dividend,
    input  logic [tbslm_pkg::DIVS_W-1:0]   divisor,
    output logic                           done,
    output logic [tbslm_pkg::DIVD_W-1:0]   quotient
);
    import tbslm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    dvs_reg, dvs_next;
    logic [DIVS_W:0]      trial;
    logic                 last_step;

    assign trial     = {rem_reg, quo_reg[DIVD_W-1]};
    assign last_step = (cnt_reg == DIV_CNT_W'(DIVD_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/tbslm_frame.sv */
// per-frame filters and band accumulators, one channel per step
// depends on tbslm_pkg
`timescale 1ns / 1ps

module tbslm_frame (
    input  logic                             clk,
    input  tbslm_pkg::frame_ctrl_t           ctrl,
    input  tbslm_pkg::sample_t               sample_left,
    input  tbslm_pkg::sample_t               sample_right,
    input  logic [tbslm_pkg::BAND_W-1:0]     band_sel,
    output tbslm_pkg::sum_t                  band_sum
);
    import tbslm_pkg::*;

    sample_t slow_reg [NCH];
    sample_t fast_reg [NCH];
    sum_t    sum_reg  [NBANDS];

    sample_t                slow_next, fast_next;
    sample_t                smp, slow_cur, fast_cur;
    logic signed [SMP_W:0]  d_slow, d_fast;
    logic signed [SMP_W:0]  q_slow, q_fast;
    logic [MAG_W-1:0]       mag [3];
    sum_t                   acc_cur [3];
    sum_t                   acc_new [3];

    // divide by 2^sh, rounding toward zero
    function automatic logic signed [SMP_W:0] sdiv_pow2(input logic signed [SMP_W:0] d,
                                                         input int sh);
        logic signed [SMP_W:0] bias;
        bias = d[SMP_W] ? (SMP_W+1)'((1 << sh) - 1) : '0;
        return (d + bias) >>> sh;
    endfunction

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SMP_W:0] v);
        logic signed [SMP_W:0] n;
        n = v[SMP_W] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

    function automatic sum_t sat_add(input sum_t a, input logic [MAG_W-1:0] m);
        logic [SUM_W:0] t;
        t = {1'b0, a} + (SUM_W+1)'(m);
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    always_comb
    begin
        smp      = ctrl.ch ? sample_right : sample_left;
        slow_cur = slow_reg[ctrl.ch];
        fast_cur = fast_reg[ctrl.ch];

        d_slow    = {smp[SMP_W-1], smp} - {slow_cur[SMP_W-1], slow_cur};
        d_fast    = {smp[SMP_W-1], smp} - {fast_cur[SMP_W-1], fast_cur};
        q_slow    = sdiv_pow2(d_slow, SLOW_SH);
        q_fast    = sdiv_pow2(d_fast, FAST_SH);
        slow_next = slow_cur + q_slow[SMP_W-1:0];
        fast_next = fast_cur + q_fast[SMP_W-1:0];

        // low, mid and high band magnitudes from the updated filters
        mag[0] = abs_mag({slow_cur[SMP_W-1], slow_cur});
        mag[1] = abs_mag({fast_cur[SMP_W-1], fast_cur} - {slow_cur[SMP_W-1], slow_cur});
        mag[2] = abs_mag({smp[SMP_W-1], smp} - {fast_cur[SMP_W-1], fast_cur});

        for (int k = 0; k < 3; k++)
        begin
            acc_cur[k] = ctrl.ch ? sum_reg[3 + k] : sum_reg[k];
            acc_new[k] = sat_add(acc_cur[k], mag[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.seed)
        begin
            slow_reg[0] <= sample_left;
            fast_reg[0] <= sample_left;
            slow_reg[1] <= sample_right;
            fast_reg[1] <= sample_right;
            for (int b = 0; b < NBANDS; b++)
            begin
                sum_reg[b] <= '0;
            end
        end
        if (ctrl.filt)
        begin
            slow_reg[ctrl.ch] <= slow_next;
            fast_reg[ctrl.ch] <= fast_next;
        end
        if (ctrl.acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (ctrl.ch)
                begin
                    sum_reg[3 + k] <= acc_new[k];
                end
                else
                begin
                    sum_reg[k] <= acc_new[k];
                end
            end
        end
    end

    assign band_sum = (band_sel < BAND_W'(NBANDS)) ? sum_reg[band_sel] : '0;

endmodule

/* sv/three_band_stereo_level_meter_core.sv */
// top level of the three-band stereo level meter: sequencer, peaks, levels
// depends on tbslm_pkg, tbslm_frame and tbslm_div
`timescale 1ns / 1ps

// Stereo 16-bit frames come in as beats on the input channel; window_last
// closes an analysis window. Each channel feeds a slow (1/16) and a fast (1/4)
// one-pole low-pass seeded from the window's first frame, and the magnitudes
// of slow, fast minus slow and sample minus fast build low, mid and high band
// sums. At window end every band's energy (sum over frame count), peak,
// 0..15 target and smoothed bar level are updated, and one result beat with
// all twelve 4-bit values is sent. Frames beyond MAX_FRAMES in a window are
// dropped but window_last on them still closes the window. Timing: in_ready
// is high only while the sequencer is idle. A frame that is not the last of
// its window goes through seed, then filter and accumulate for each channel
// in turn; a dropped frame only passes the seed state. A window-closing frame
// then updates the bands one at a time, almost all of the work in the single
// shared 23-step divider that first gives the energy and then the target (the
// second division is skipped for a band whose peak is zero).
// The result sits in an output register, so the next window's frames are
// taken while it waits; only the final band update waits for that register
// to be free.
module three_band_stereo_level_meter_core #(
    parameter int MAX_FRAMES = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  tbslm_pkg::sample_t   left_sample,
    input  tbslm_pkg::sample_t   right_sample,
    input  logic                 window_last,

    output logic                 out_valid,
    input  logic                 out_ready,
    output tbslm_pkg::level_t    level_left_low,
    output tbslm_pkg::level_t    level_left_mid,
    output tbslm_pkg::level_t    level_left_high,
    output tbslm_pkg::level_t    level_right_low,
    output tbslm_pkg::level_t    level_right_mid,
    output tbslm_pkg::level_t    level_right_high,
    output tbslm_pkg::level_t    target_left_low,
    output tbslm_pkg::level_t    target_left_mid,
    output tbslm_pkg::level_t    target_left_high,
    output tbslm_pkg::level_t    target_right_low,
    output tbslm_pkg::level_t    target_right_mid,
    output tbslm_pkg::level_t    target_right_high
);
    import tbslm_pkg::*;

    // frame counter must hold MAX_FRAMES itself
    localparam int FCNT_W = $clog2(MAX_FRAMES + 1);

    tbslm_state_t state_reg, state_next;

    // latched input beat
    sample_t            sample_l_reg, sample_l_next;
    sample_t            sample_r_reg, sample_r_next;
    logic               last_reg, last_next;

    // window bookkeeping
    logic               open_reg, open_next;
    logic [FCNT_W-1:0]  fcount_reg, fcount_next;
    logic               ch_reg, ch_next;
    logic [BAND_W-1:0]  band_reg, band_next;

    // window-end working values
    logic [PEAK_W-1:0]  energy_reg, energy_next;
    level_t             tgt_reg, tgt_next;
    logic [PEAK_W-1:0]  peak_reg [NBANDS];
    logic [PEAK_W-1:0]  peak_next [NBANDS];
    level_t             level_reg [NBANDS];
    level_t             level_next [NBANDS];
    level_t             target_reg [NBANDS];
    level_t             target_next [NBANDS];

    // result register
    logic               out_valid_reg, out_valid_next;
    level_t             out_level_reg [NBANDS];
    level_t             out_level_next [NBANDS];
    level_t             out_target_reg [NBANDS];
    level_t             out_target_next [NBANDS];

    frame_ctrl_t        frame_ctrl;
    sum_t               sum_sel;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;

    logic               frame_room;
    logic               level_go;
    logic [PEAK_W-1:0]  peak_cur, peak_upd;
    logic [PEAK_W+3:0]  energy_x15;
    level_t             lvl_cur, lvl_upd, lvl_gap;
    logic [DIVS_W-1:0]  frames_div;

    tbslm_frame u_frame (
        .clk          (clk),
        .ctrl         (frame_ctrl),
        .sample_left  (sample_l_reg),
        .sample_right (sample_r_reg),
        .band_sel     (band_reg),
        .band_sum     (sum_sel)
    );

    tbslm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // frames still counted in this window
    assign frame_room = (fcount_reg < FCNT_W'(MAX_FRAMES));

    // last band may only finish once the result register is free
    assign level_go = (band_reg != LAST_BAND) || !out_valid_reg || out_ready;

    // peak follows rises at once, otherwise decays by 1/32 above the floor
    assign peak_cur = peak_reg[band_reg];
    always_comb
    begin
        if (energy_reg > peak_cur)
        begin
            peak_upd = energy_reg;
        end
        else if (peak_cur > PEAK_FLOOR)
        begin
            peak_upd = peak_cur - (peak_cur >> DECAY_SH);
        end
        else
        begin
            peak_upd = peak_cur;
        end
    end

    // energy * 15 as a shift and subtract
    assign energy_x15 = {energy_reg, 4'b0000} - {4'b0000, energy_reg};

    // a one-frame window never has zero count, but keep the divisor sane
    assign frames_div = (fcount_reg == '0) ? DIVS_W'(1) : DIVS_W'(fcount_reg);

    // bar climbs by up to three, falls by one
    assign lvl_cur = level_reg[band_reg];
    assign lvl_gap = tgt_reg - lvl_cur;
    always_comb
    begin
        if (lvl_cur < tgt_reg)
        begin
            lvl_upd = lvl_cur + ((lvl_gap > LVL_CLIMB) ? LVL_CLIMB : lvl_gap);
        end
        else if (lvl_cur > tgt_reg)
        begin
            lvl_upd = lvl_cur - LVL_W'(1);
        end
        else
        begin
            lvl_upd = lvl_cur;
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                // a fresh window always has room for its first frame
                if (!open_reg || frame_room)
                begin
                    state_next = ST_FILT;
                end
                else if (last_reg)
                begin
                    state_next = ST_E_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILT:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!ch_reg)
                begin
                    state_next = ST_FILT;
                end
                else if (last_reg)
                begin
                    state_next = ST_E_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_E_START:
            begin
                state_next = ST_E_WAIT;
            end
            ST_E_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                state_next = ST_T_START;
            end
            ST_T_START:
            begin
                // zero peak means zero target, no division needed
                if (peak_cur == '0)
                begin
                    state_next = ST_LEVEL;
                end
                else
                begin
                    state_next = ST_T_WAIT;
                end
            end
            ST_T_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                if (level_go)
                begin
                    state_next = (band_reg == LAST_BAND) ? ST_IDLE : ST_E_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_ready        = 1'b0;
        frame_ctrl      = '0;
        frame_ctrl.ch   = ch_reg;
        div_start       = 1'b0;
        div_dividend    = sum_sel;
        div_divisor     = frames_div;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SEED:
            begin
                frame_ctrl.seed = !open_reg;
            end
            ST_FILT:
            begin
                frame_ctrl.filt = 1'b1;
            end
            ST_ACC:
            begin
                frame_ctrl.acc = 1'b1;
            end
            ST_E_START:
            begin
                div_start = 1'b1;
            end
            ST_T_START:
            begin
                div_start    = (peak_cur != '0);
                div_dividend = DIVD_W'(energy_x15);
                div_divisor  = DIVS_W'(peak_cur);
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        sample_l_next   = sample_l_reg;
        sample_r_next   = sample_r_reg;
        last_next       = last_reg;
        open_next       = open_reg;
        fcount_next     = fcount_reg;
        ch_next         = ch_reg;
        band_next       = band_reg;
        energy_next     = energy_reg;
        tgt_next        = tgt_reg;
        peak_next       = peak_reg;
        level_next      = level_reg;
        target_next     = target_reg;
        out_level_next  = out_level_reg;
        out_target_next = out_target_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_l_next = left_sample;
                    sample_r_next = right_sample;
                    last_next     = window_last;
                    band_next     = '0;
                end
            end
            ST_SEED:
            begin
                open_next = 1'b1;
                ch_next   = 1'b0;
                if (!open_reg)
                begin
                    fcount_next = '0;
                end
            end
            ST_ACC:
            begin
                ch_next = !ch_reg;
                if (ch_reg)
                begin
                    fcount_next = fcount_reg + FCNT_W'(1);
                end
            end
            ST_E_WAIT:
            begin
                if (div_done)
                begin
                    energy_next = (|div_quo[DIVD_W-1:PEAK_W]) ? '1 : div_quo[PEAK_W-1:0];
                end
            end
            ST_PEAK:
            begin
                peak_next[band_reg] = peak_upd;
            end
            ST_T_START:
            begin
                if (peak_cur == '0)
                begin
                    tgt_next = '0;
                end
            end
            ST_T_WAIT:
            begin
                if (div_done)
                begin
                    tgt_next = (|div_quo[DIVD_W-1:LVL_W]) ? LVL_MAX : div_quo[LVL_W-1:0];
                end
            end
            ST_LEVEL:
            begin
                if (level_go)
                begin
                    level_next[band_reg]  = lvl_upd;
                    target_next[band_reg] = tgt_reg;
                    if (band_reg == LAST_BAND)
                    begin
                        // window closed: publish and start over
                        out_level_next  = level_next;
                        out_target_next = target_next;
                        out_valid_next  = 1'b1;
                        open_next       = 1'b0;
                        fcount_next     = '0;
                        band_next       = '0;
                    end
                    else
                    begin
                        band_next = band_reg + BAND_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            fcount_reg    <= '0;
            ch_reg        <= 1'b0;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NBANDS; b++)
            begin
                peak_reg[b]  <= '0;
                level_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            fcount_reg    <= fcount_next;
            ch_reg        <= ch_next;
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
            peak_reg      <= peak_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_l_reg   <= sample_l_next;
        sample_r_reg   <= sample_r_next;
        last_reg       <= last_next;
        energy_reg     <= energy_next;
        tgt_reg        <= tgt_next;
        target_reg     <= target_next;
        out_level_reg  <= out_level_next;
        out_target_reg <= out_target_next;
    end

    assign out_valid         = out_valid_reg;
    assign level_left_low    = out_level_reg[0];
    assign level_left_mid    = out_level_reg[1];
    assign level_left_high   = out_level_reg[2];
    assign level_right_low   = out_level_reg[3];
    assign level_right_mid   = out_level_reg[4];
    assign level_right_high  = out_level_reg[5];
    assign target_left_low   = out_target_reg[0];
    assign target_left_mid   = out_target_reg[1];
    assign target_left_high  = out_target_reg[2];
    assign target_right_low  = out_target_reg[3];
    assign target_right_mid  = out_target_reg[4];
    assign target_right_high = out_target_reg[5];

endmodule

/* sv/tbslm_checker.sv */
// port-level checker for the three-band stereo level meter, bound to the top
// depends on three_band_stereo_level_meter_core_macros.svh
`timescale 1ns / 1ps
`include "three_band_stereo_level_meter_core_macros.svh"

module tbslm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] left_sample,
    input logic signed [15:0] right_sample,
    input logic               window_last,
    input logic               out_valid,
    input logic               out_ready,
    input logic [3:0]         level_left_low,
    input logic [3:0]         level_left_mid,
    input logic [3:0]         level_left_high,
    input logic [3:0]         level_right_low,
    input logic [3:0]         level_right_mid,
    input logic [3:0]         level_right_high,
    input logic [3:0]         target_left_low,
    input logic [3:0]         target_left_mid,
    input logic [3:0]         target_left_high,
    input logic [3:0]         target_right_low,
    input logic [3:0]         target_right_mid,
    input logic [3:0]         target_right_high
);

    logic [47:0] out_bus;
    logic        in_beat;

    assign out_bus = {level_left_low, level_left_mid, level_left_high,
                      level_right_low, level_right_mid, level_right_high,
                      target_left_low, target_left_mid, target_left_high,
                      target_right_low, target_right_mid, target_right_high};
    assign in_beat = in_valid && in_ready;

    // a stalled result beat holds
    `TBSLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))

    // each input beat makes the sequencer busy, so in_ready is low in the next cycle
    `TBSLM_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_beat, !in_ready)

    // no result can appear right after a frame is taken
    `TBSLM_ASSERT_NEXT(a_no_quick_result, clk, rst_n, in_beat, !$rose(out_valid))

endmodule

bind three_band_stereo_level_meter_core tbslm_checker u_tbslm_checker (.*);
